@@ rtl/bb3_pkg.sv @@
// ----------------------------------------------------------------------------
// bb3_pkg
// Shared types, register codes and constants of the 3x3 box blur stream core.
// ----------------------------------------------------------------------------
package bb3_pkg;

    // configuration port
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // input word kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    // datapath widths
    localparam int CH_W   = 8;   // one color channel
    localparam int CSUM_W = 10;  // sum of one window column (3 pixels)
    localparam int SUM_W  = 12;  // sum of the full window (9 pixels)
    localparam int POS_W  = 10;  // reported pixel position
    localparam int ROW_W  = 11;  // row counters

    // divide by 9: multiply by ceil(2^16 / 9), keep bits above 2^16
    localparam int              DIV9_SHIFT = 16;
    localparam int              RECIP_W    = 13;
    localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [CSUM_W-1:0] red;
        logic [CSUM_W-1:0] green;
        logic [CSUM_W-1:0] blue;
    } t_csum;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } t_pos;

    // exact for any window sum up to 9 * 255
    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+RECIP_W-1:0] p;
        p = (SUM_W+RECIP_W)'(s) * (SUM_W+RECIP_W)'(DIV9_RECIP);
        return p[DIV9_SHIFT +: CH_W];
    endfunction

    // add the three pixels of one window column
    function automatic t_csum col_sum(input t_rgb a, input t_rgb b, input t_rgb c);
        t_csum s;
        s.red   = CSUM_W'(a.red)   + CSUM_W'(b.red)   + CSUM_W'(c.red);
        s.green = CSUM_W'(a.green) + CSUM_W'(b.green) + CSUM_W'(c.green);
        s.blue  = CSUM_W'(a.blue)  + CSUM_W'(b.blue)  + CSUM_W'(c.blue);
        return s;
    endfunction

endpackage

@@ rtl/bb3_stream_if.sv @@
// ----------------------------------------------------------------------------
// bb3 stream interfaces
// Valid/ready channels for source pixels and blurred result pixels.
// ----------------------------------------------------------------------------
interface bb3_in_if;
    import bb3_pkg::*;

    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;

    modport source (output valid, kind, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, kind, in_red, in_green, in_blue, output ready);
endinterface

interface bb3_out_if;
    import bb3_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_red;
    logic [CH_W-1:0]  out_green;
    logic [CH_W-1:0]  out_blue;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic             out_last;

    modport source (output valid, out_red, out_green, out_blue, out_x, out_y, out_last,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, out_x, out_y, out_last,
                    output ready);
endinterface

@@ rtl/bb3_line_store.sv @@
// ----------------------------------------------------------------------------
// bb3_line_store
// Two line memories holding the two rows above the incoming one, with a
// registered read and a bypass for a write to the address being read.
// ----------------------------------------------------------------------------
module bb3_line_store #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_rd_addr,
    input  logic                         i_wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_wr_addr,
    input  bb3_pkg::t_rgb                i_wr_upper,
    input  bb3_pkg::t_rgb                i_wr_lower,
    output bb3_pkg::t_rgb                o_upper,
    output bb3_pkg::t_rgb                o_lower
);
    import bb3_pkg::*;

    t_rgb r_upper_mem [MAX_WIDTH];
    t_rgb r_lower_mem [MAX_WIDTH];
    t_rgb r_upper_q;
    t_rgb r_lower_q;
    logic r_fwd;
    t_rgb r_fwd_upper;
    t_rgb r_fwd_lower;

    // write the shifted column, read the next column
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper_mem[i_wr_addr] <= i_wr_upper;
            r_lower_mem[i_wr_addr] <= i_wr_lower;
        end
        if (i_rd_en) begin
            r_upper_q <= r_upper_mem[i_rd_addr];
            r_lower_q <= r_lower_mem[i_rd_addr];
        end
    end

    // catch a write that lands on the address read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_upper <= i_wr_upper;
            r_fwd_lower <= i_wr_lower;
        end
    end

    assign o_upper = r_fwd ? r_fwd_upper : r_upper_q;
    assign o_lower = r_fwd ? r_fwd_lower : r_lower_q;

endmodule

@@ rtl/box_blur_3x3_stream_core.sv @@
// ----------------------------------------------------------------------------
// box_blur_3x3_stream_core
// 3x3 box blur over a raster pixel stream, divisor 9, out-of-frame pixels zero.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle in and out while o_blur is not stalled, set by
//   the single-port-per-side line memories that are read and written once per word.
// Pipeline: the result for pixel (x,y) passes stages A, B and C after the word at
//   raster position (y+1)*W + x+1 is accepted; W+1 drain words end a frame.
// Reset: synchronous, active low; clears counters, window and pipeline and
//   restores a 640x480 frame. Line memories are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_stream_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [bb3_pkg::CFG_W-1:0]       i_cfg_data,
    bb3_in_if.sink                          i_pix,
    bb3_out_if.source                       o_blur
);
    import bb3_pkg::*;

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = XW + CFG_W + 1;

    // configuration
    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;

    // position counters
    logic [XW-1:0]    r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [XW-1:0]    r_out_col;
    logic [ROW_W-1:0] r_out_row;

    // accept-side decode
    logic accept, take, row_in_frame, drop, pixel;
    logic use_up, use_lo, emit, in_col_wrap, out_col_wrap, out_row_end, last;

    // stage A: word plus line memory data
    logic          r_a_valid;
    logic          r_a_pixel;
    t_rgb          r_a_rgb;
    logic [XW-1:0] r_a_col;
    logic          r_a_use_up;
    logic          r_a_use_lo;
    logic          r_a_emit;
    logic          r_a_skip_l;
    logic          r_a_skip_r;
    t_pos          r_a_pos;

    t_rgb  mem_upper, mem_lower;
    t_rgb  col_up, col_lo, col_new;
    t_csum new_csum;
    t_csum r_win [2];

    // stage B: window column sums
    logic  r_b_valid;
    t_csum r_b_left, r_b_cent, r_b_right;
    logic  r_b_skip_l, r_b_skip_r;
    t_pos  r_b_pos;

    // stage C: result register
    logic r_c_valid;
    t_rgb r_c_rgb;
    t_pos r_c_pos;

    logic ready_a, ready_b, ready_c, a_fire, b_fire;
    logic [SUM_W-1:0] sum_red, sum_green, sum_blue;

    // clamp the frame size to at least 1 and at most MAX_WIDTH by MAX_HEIGHT
    always_comb begin
        if (r_frame_width == '0) begin
            w = CFG_W'(1);
        end else if (CMP_W'(r_frame_width) > CMP_W'(MAX_WIDTH)) begin
            w = CFG_W'(MAX_WIDTH);
        end else begin
            w = r_frame_width;
        end
        if (r_frame_height == '0) begin
            h = CFG_W'(1);
        end else if (CMP_W'(r_frame_height) > CMP_W'(MAX_HEIGHT)) begin
            h = CFG_W'(MAX_HEIGHT);
        end else begin
            h = r_frame_height;
        end
    end

    // pipeline flow control
    assign ready_c     = !r_c_valid || o_blur.ready;
    assign ready_b     = !r_b_valid || ready_c;
    assign ready_a     = !r_a_valid || ready_b;
    assign a_fire      = r_a_valid && ready_b;
    assign b_fire      = r_b_valid && ready_c;
    assign i_pix.ready = ready_a;

    // classify the incoming word
    assign accept       = i_pix.valid && ready_a;
    assign row_in_frame = CMP_W'(r_in_row) < CMP_W'(h);
    assign drop         = (i_pix.kind == KIND_DRAIN) && row_in_frame;
    assign pixel        = (i_pix.kind == KIND_PIXEL) && row_in_frame;
    assign take         = accept && !drop;
    assign use_up       = (r_in_row >= ROW_W'(2))
                          && (CMP_W'(r_in_row - ROW_W'(2)) < CMP_W'(h));
    assign use_lo       = (r_in_row >= ROW_W'(1))
                          && (CMP_W'(r_in_row - ROW_W'(1)) < CMP_W'(h));
    assign emit         = (r_in_row >= ROW_W'(2))
                          || ((r_in_row == ROW_W'(1)) && (r_in_col != '0));
    assign in_col_wrap  = (CMP_W'(r_in_col) + CMP_W'(1)) >= CMP_W'(w);
    assign out_col_wrap = (CMP_W'(r_out_col) + CMP_W'(1)) >= CMP_W'(w);
    assign out_row_end  = (CMP_W'(r_out_row) + CMP_W'(1)) >= CMP_W'(h);
    assign last         = out_col_wrap && out_row_end;

    // configuration writes and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                    r_in_col      <= '0;
                    r_in_row      <= '0;
                    r_out_col     <= '0;
                    r_out_row     <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                    r_in_col       <= '0;
                    r_in_row       <= '0;
                    r_out_col      <= '0;
                    r_out_row      <= '0;
                end
                default: begin
                end
            endcase
        end else if (take) begin
            if (emit && last) begin
                // frame done: restart all counters
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_wrap) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= r_in_col + XW'(1);
                end
                if (emit) begin
                    if (out_col_wrap) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + ROW_W'(1);
                    end else begin
                        r_out_col <= r_out_col + XW'(1);
                    end
                end
            end
        end
    end

    // stage A valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (ready_a) begin
            r_a_valid <= take;
        end
    end

    // stage A payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_pixel  <= pixel;
            r_a_rgb    <= '{red: i_pix.in_red, green: i_pix.in_green, blue: i_pix.in_blue};
            r_a_col    <= r_in_col;
            r_a_use_up <= use_up;
            r_a_use_lo <= use_lo;
            r_a_emit   <= emit;
            r_a_skip_l <= (r_out_col == '0);
            r_a_skip_r <= (r_in_col == '0);
            r_a_pos    <= '{x: POS_W'(r_out_col), y: POS_W'(r_out_row), last: last};
        end
    end

    bb3_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (take),
        .i_rd_addr  (r_in_col),
        .i_wr_en    (a_fire),
        .i_wr_addr  (r_a_col),
        .i_wr_upper (mem_lower),
        .i_wr_lower (col_new),
        .o_upper    (mem_upper),
        .o_lower    (mem_lower)
    );

    // mask rows outside the frame, build the new window column
    assign col_up   = r_a_use_up ? mem_upper : '0;
    assign col_lo   = r_a_use_lo ? mem_lower : '0;
    assign col_new  = r_a_pixel  ? r_a_rgb   : '0;
    assign new_csum = col_sum(col_up, col_lo, col_new);

    // shift the column-sum window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win[0] <= '0;
            r_win[1] <= '0;
        end else if (a_fire) begin
            r_win[0] <= r_win[1];
            r_win[1] <= new_csum;
        end
    end

    // stage B valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (ready_b) begin
            r_b_valid <= r_a_valid && r_a_emit;
        end
    end

    // stage B payload: left and center columns from the window, right column new
    always_ff @(posedge i_clk) begin
        if (a_fire && r_a_emit) begin
            r_b_left   <= r_win[0];
            r_b_cent   <= r_win[1];
            r_b_right  <= new_csum;
            r_b_skip_l <= r_a_skip_l;
            r_b_skip_r <= r_a_skip_r;
            r_b_pos    <= r_a_pos;
        end
    end

    // add the in-frame columns
    always_comb begin
        sum_red   = SUM_W'(r_b_cent.red);
        sum_green = SUM_W'(r_b_cent.green);
        sum_blue  = SUM_W'(r_b_cent.blue);
        if (!r_b_skip_l) begin
            sum_red   = sum_red   + SUM_W'(r_b_left.red);
            sum_green = sum_green + SUM_W'(r_b_left.green);
            sum_blue  = sum_blue  + SUM_W'(r_b_left.blue);
        end
        if (!r_b_skip_r) begin
            sum_red   = sum_red   + SUM_W'(r_b_right.red);
            sum_green = sum_green + SUM_W'(r_b_right.green);
            sum_blue  = sum_blue  + SUM_W'(r_b_right.blue);
        end
    end

    // stage C valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (ready_c) begin
            r_c_valid <= r_b_valid;
        end
    end

    // stage C payload: divide by 9
    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_c_rgb <= '{red: div9(sum_red), green: div9(sum_green), blue: div9(sum_blue)};
            r_c_pos <= r_b_pos;
        end
    end

    assign o_blur.valid     = r_c_valid;
    assign o_blur.out_red   = r_c_rgb.red;
    assign o_blur.out_green = r_c_rgb.green;
    assign o_blur.out_blue  = r_c_rgb.blue;
    assign o_blur.out_x     = r_c_pos.x;
    assign o_blur.out_y     = r_c_pos.y;
    assign o_blur.out_last  = r_c_pos.last;

endmodule
